// File: hw/rtl/rbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbe_pkg;

    localparam int BLOCK_MAX     = 63;
    localparam int SPLIT_OPTIONS = 16;
    localparam int ID_BITS       = 4;

    localparam int SAMPLE_W = 18;
    localparam int VALUE_W  = 19;
    localparam int COST_W   = 25;
    localparam int SPLIT_W  = 4;
    localparam int QUOT_W   = 19;
    localparam int REM_W    = 15;
    localparam int HCOST_W  = 24;

    localparam int DEPTH = BLOCK_MAX + 1;
    localparam int CNT_W = $clog2(DEPTH);
    localparam int K_W   = $clog2(SPLIT_OPTIONS);

    typedef enum logic [1:0] {
        COST_HOLD,
        COST_ACC,
        COST_SCAN,
        COST_CLEAR
    } t_cost_op;

    typedef struct packed {
        t_cost_op       op;
        logic [K_W-1:0] k;
    } t_cost_ctl;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic [SPLIT_W-1:0] split_bits;
        logic [QUOT_W-1:0]  quotient;
        logic [REM_W-1:0]   remainder;
        logic [HCOST_W-1:0] cost_bits;
        logic               last;
    } t_out;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_CODE   = 1'b1;

endpackage

`default_nettype wire

// File: hw/rtl/rice_block_encoder.sv
// Non-final item: busy while its cost is added for each split count in turn through the shared cost adder.
// Final item: its cost is added for each split count (skipped when a full buffer drops it), then each
// split count is compared, then the header is shown, then one code per buffered value on consecutive cycles.
// A new item is accepted only while the encoder is idle, so each item is finished before the next is taken.
// Results cannot be stalled; each is shown for exactly one cycle under o_strobe.
// Synchronous active-low reset clears the count, the costs and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rice_block_encoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rbe_pkg::t_in  i_item,
    output logic               o_strobe,
    output rbe_pkg::t_out      o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_SCAN,
        S_HEAD,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [rbe_pkg::CNT_W-1:0]    r_count;
    logic [rbe_pkg::CNT_W-1:0]    r_idx;
    logic [rbe_pkg::K_W-1:0]      r_k;
    logic [rbe_pkg::VALUE_W-1:0]  r_v;
    logic                         r_end;
    logic                         r_strobe;
    rbe_pkg::t_out                r_out;

    logic                         accept;
    logic                         full;
    logic [rbe_pkg::VALUE_W-1:0]  mapped;
    logic [rbe_pkg::VALUE_W-1:0]  rdata;
    logic                         ram_we;
    rbe_pkg::t_cost_ctl           cost_ctl;
    logic [rbe_pkg::K_W-1:0]      best_k;
    logic [rbe_pkg::COST_W-1:0]   best_cost;
    logic                         code_last;
    logic [rbe_pkg::VALUE_W-1:0]  rem_mask;

    function automatic logic [rbe_pkg::VALUE_W-1:0] map_sample(
        input logic [rbe_pkg::SAMPLE_W-1:0] x
    );
        logic [rbe_pkg::SAMPLE_W-1:0] mag;
        mag = rbe_pkg::SAMPLE_W'(0) - x;
        if (x[rbe_pkg::SAMPLE_W-1]) begin
            return {mag, 1'b0};
        end
        return {x, 1'b0} - rbe_pkg::VALUE_W'(x != '0);
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_count == rbe_pkg::CNT_W'(rbe_pkg::BLOCK_MAX));
    assign mapped = map_sample(i_item.sample);
    assign ram_we = accept && !full;

    rbe_ram #(
        .WIDTH(rbe_pkg::VALUE_W),
        .DEPTH(rbe_pkg::DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count),
        .i_wdata(mapped),
        .i_raddr(r_idx),
        .o_rdata(rdata)
    );

    // The final code is the one whose successor index equals the count.
    assign code_last = (r_idx == r_count);

    always_comb begin
        cost_ctl.k = r_k;
        unique case (r_state)
            S_ACC:   cost_ctl.op = rbe_pkg::COST_ACC;
            S_SCAN:  cost_ctl.op = rbe_pkg::COST_SCAN;
            S_EMIT:  cost_ctl.op = code_last ? rbe_pkg::COST_CLEAR : rbe_pkg::COST_HOLD;
            default: cost_ctl.op = rbe_pkg::COST_HOLD;
        endcase
    end

    rbe_cost u_cost (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (cost_ctl),
        .i_value    (r_v),
        .o_best_k   (best_k),
        .o_best_cost(best_cost)
    );

    assign rem_mask = (rbe_pkg::VALUE_W'(1) << best_k) - rbe_pkg::VALUE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_k      <= '0;
            r_end    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (accept) begin
                        r_end <= i_item.block_end;
                        if (!full) begin
                            r_v     <= mapped;
                            r_count <= r_count + rbe_pkg::CNT_W'(1);
                            r_state <= S_ACC;
                        end else if (i_item.block_end) begin
                            // A full buffer drops the value but still closes the block.
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_ACC: begin
                    r_strobe <= 1'b0;
                    if (r_k == rbe_pkg::K_W'(rbe_pkg::SPLIT_OPTIONS - 1)) begin
                        r_k     <= '0;
                        r_state <= r_end ? S_SCAN : S_IDLE;
                    end else begin
                        r_k <= r_k + rbe_pkg::K_W'(1);
                    end
                end
                S_SCAN: begin
                    r_strobe <= 1'b0;
                    if (r_k == rbe_pkg::K_W'(rbe_pkg::SPLIT_OPTIONS - 1)) begin
                        r_k     <= '0;
                        r_state <= S_HEAD;
                    end else begin
                        r_k <= r_k + rbe_pkg::K_W'(1);
                    end
                end
                S_HEAD: begin
                    r_strobe            <= 1'b1;
                    r_out.kind          <= rbe_pkg::KIND_HEADER;
                    r_out.split_bits    <= rbe_pkg::SPLIT_W'(best_k);
                    r_out.quotient      <= '0;
                    r_out.remainder     <= '0;
                    r_out.cost_bits     <= rbe_pkg::HCOST_W'(best_cost
                                           + rbe_pkg::COST_W'(rbe_pkg::ID_BITS));
                    r_out.last          <= 1'b0;
                    r_idx               <= r_idx + rbe_pkg::CNT_W'(1);
                    r_state             <= S_EMIT;
                end
                S_EMIT: begin
                    r_strobe         <= 1'b1;
                    r_out.kind       <= rbe_pkg::KIND_CODE;
                    r_out.split_bits <= rbe_pkg::SPLIT_W'(best_k);
                    r_out.quotient   <= rbe_pkg::QUOT_W'(rdata >> best_k);
                    r_out.remainder  <= rbe_pkg::REM_W'(rdata & rem_mask);
                    r_out.cost_bits  <= '0;
                    r_out.last       <= code_last;
                    if (code_last) begin
                        r_idx   <= '0;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + rbe_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/rbe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/rbe_cost.sv
`timescale 1ns / 1ps
`default_nettype none

module rbe_cost (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rbe_pkg::t_cost_ctl            i_ctl,
    input  wire logic [rbe_pkg::VALUE_W-1:0]   i_value,
    output logic      [rbe_pkg::K_W-1:0]       o_best_k,
    output logic      [rbe_pkg::COST_W-1:0]    o_best_cost
);

    logic [rbe_pkg::COST_W-1:0] r_cost [rbe_pkg::SPLIT_OPTIONS];
    logic [rbe_pkg::COST_W-1:0] r_best_cost;
    logic [rbe_pkg::K_W-1:0]    r_best_k;
    logic [rbe_pkg::COST_W-1:0] n_sum;
    logic [rbe_pkg::COST_W-1:0] cur;

    assign cur = r_cost[i_ctl.k];

    // The shared adder: each split count costs k plus the quotient plus the stop bit.
    assign n_sum = cur + rbe_pkg::COST_W'(i_ctl.k)
                 + rbe_pkg::COST_W'(i_value >> i_ctl.k) + rbe_pkg::COST_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rbe_pkg::SPLIT_OPTIONS; i++) begin
                r_cost[i] <= '0;
            end
            r_best_cost <= '0;
            r_best_k    <= '0;
        end else begin
            case (i_ctl.op)
                rbe_pkg::COST_ACC: begin
                    r_cost[i_ctl.k] <= n_sum;
                end
                rbe_pkg::COST_SCAN: begin
                    // Strict compare keeps the smallest k on a tie.
                    if (i_ctl.k == '0 || cur < r_best_cost) begin
                        r_best_cost <= cur;
                        r_best_k    <= i_ctl.k;
                    end
                end
                rbe_pkg::COST_CLEAR: begin
                    for (int i = 0; i < rbe_pkg::SPLIT_OPTIONS; i++) begin
                        r_cost[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_best_k    = r_best_k;
    assign o_best_cost = r_best_cost;

endmodule

`default_nettype wire

// File: hw/rtl/rbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rbe_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire logic          o_strobe,
    input  wire rbe_pkg::t_out o_result
);

    // An accepted item never produces a result on the very next cycle.
    a_no_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_strobe)
        else $error("result right after an accepted item");

    a_header_then_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == rbe_pkg::KIND_HEADER
        |=> o_strobe && o_result.kind == rbe_pkg::KIND_CODE)
        else $error("header not followed by a code");

    a_codes_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == rbe_pkg::KIND_CODE && !o_result.last
        |=> o_strobe && o_result.kind == rbe_pkg::KIND_CODE)
        else $error("gap inside the code run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.kind == rbe_pkg::KIND_CODE && o_result.last |=> !o_strobe)
        else $error("result after the final code");

    a_busy_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !(o_result.kind == rbe_pkg::KIND_CODE && o_result.last) |-> busy)
        else $error("idle while codes remain");

endmodule

bind rice_block_encoder rbe_checker u_rbe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

`default_nettype wire

// File: tb/sv/rice_block_encoder_tb.sv
`timescale 1ns / 1ps

module rice_block_encoder_tb;
    import rbe_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int VALUE_TARGET = 365;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in i_item;
    logic o_strobe;
    t_out o_result;

    rice_block_encoder uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Encoder state as the testbench sees it.
    logic [VALUE_W-1:0] held_values [DEPTH];
    int held_count;
    logic [COST_W-1:0] run_costs [SPLIT_OPTIONS];
    t_out pending_codes [$];

    int errors;
    int values_sent;
    int values_dropped;
    int blocks_closed;
    int headers_checked;
    int codes_checked;
    int gap_ceiling;
    int cycle_count;
    logic [SPLIT_OPTIONS-1:0] splits_chosen;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
    end

    function automatic logic [VALUE_W-1:0] fold_sign(input logic signed [SAMPLE_W-1:0] s);
        int x;
        x = s;
        if (x < 0) begin
            return VALUE_W'(-2 * x);
        end else if (x > 0) begin
            return VALUE_W'(2 * x - 1);
        end
        return '0;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 60) begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic encoder_accept(input t_in it);
        logic [VALUE_W-1:0] v;
        logic [COST_W-1:0] bmin;
        int best;
        int k;
        int i;
        t_out r;
        if (held_count < BLOCK_MAX) begin
            v = fold_sign(it.sample);
            held_values[held_count] = v;
            held_count++;
            for (k = 0; k < SPLIT_OPTIONS; k++) begin
                run_costs[k] = run_costs[k] + COST_W'(k) + COST_W'(v >> k) + COST_W'(1);
            end
        end else begin
            // A full buffer drops the value, but block_end still closes the block.
            values_dropped++;
        end
        if (it.block_end) begin
            best = 0;
            bmin = run_costs[0];
            for (k = 1; k < SPLIT_OPTIONS; k++) begin
                if (run_costs[k] < bmin) begin
                    bmin = run_costs[k];
                    best = k;
                end
            end
            r = '0;
            r.kind = KIND_HEADER;
            r.split_bits = SPLIT_W'(best);
            r.cost_bits = HCOST_W'(bmin + ID_BITS);
            pending_codes.push_back(r);
            for (i = 0; i < held_count; i++) begin
                r = '0;
                r.kind = KIND_CODE;
                r.split_bits = SPLIT_W'(best);
                r.quotient = QUOT_W'(held_values[i] >> best);
                r.remainder = REM_W'(held_values[i] & ((VALUE_W'(1) << best) - VALUE_W'(1)));
                r.last = (i == held_count - 1);
                pending_codes.push_back(r);
            end
            splits_chosen[best] = 1'b1;
            held_count = 0;
            for (k = 0; k < SPLIT_OPTIONS; k++) begin
                run_costs[k] = '0;
            end
            blocks_closed++;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic check_code(input t_out got);
        t_out want;
        if (pending_codes.size() == 0) begin
            report_mismatch("result strobe with no result expected");
        end else begin
            want = pending_codes.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("split_bits", got.split_bits, want.split_bits);
            compare_field("quotient", got.quotient, want.quotient);
            compare_field("remainder", got.remainder, want.remainder);
            compare_field("cost_bits", got.cost_bits, want.cost_bits);
            compare_field("last", got.last, want.last);
            if (want.kind == KIND_HEADER) begin
                headers_checked++;
            end else begin
                codes_checked++;
            end
        end
    endtask

    // Prediction runs before the check in the same block, so an immediate
    // result could never race its own expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                encoder_accept(i_item);
            end
            if (o_strobe) begin
                check_code(o_result);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_codes.size());
        $display("TEST FAILED");
        $finish;
    end

    // Leaves start high after the accepting edge; the caller either sends the
    // next item or calls release_start.
    task automatic send_value(input logic signed [SAMPLE_W-1:0] s, input logic last_one);
        int gap;
        t_in it;
        gap = $urandom_range(0, gap_ceiling);
        it.sample = s;
        it.block_end = last_one;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        values_sent++;
    endtask

    task automatic release_start();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_for_codes();
        release_start();
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int scale);
        int pick;
        int mag;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            return SAMPLE_W'($urandom);
        end else if (pick == 1) begin
            return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
        end
        mag = $urandom_range(0, (1 << scale) - 1);
        return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    endfunction

    task automatic send_block(input int len, input int scale);
        int i;
        for (i = 0; i < len; i++) begin
            send_value(rand_sample(scale), i == len - 1);
        end
    endtask

    task automatic test_single_value_blocks();
        // Zero, the smallest codes, a tie between split counts and both range ends.
        gap_ceiling = 7;
        send_value(18'sd0, 1'b1);
        send_value(18'sd1, 1'b1);
        send_value(-18'sd1, 1'b1);
        send_value(18'sd2, 1'b1);
        send_value(18'sh1FFFF, 1'b1);
        send_value(18'sh20000, 1'b1);
        release_start();
    endtask

    task automatic test_short_blocks();
        int i;
        gap_ceiling = 0;
        for (i = 0; i < 4; i++) begin
            send_value(18'sd0, i == 3);
        end
        gap_ceiling = 7;
        send_value(18'sh1FFFF, 1'b0);
        send_value(18'sh20000, 1'b0);
        send_value(18'sd2, 1'b0);
        send_value(-18'sd2, 1'b0);
        send_value(18'sd7, 1'b1);
        release_start();
    endtask

    task automatic test_buffer_full();
        int i;
        gap_ceiling = 3;
        // Exactly full: no value is dropped.
        send_block(BLOCK_MAX, 10);
        // Largest magnitudes fill the buffer, and the closing value is dropped.
        gap_ceiling = 7;
        for (i = 0; i < BLOCK_MAX; i++) begin
            send_value(18'sh20000, 1'b0);
        end
        send_value(18'sh1FFFF, 1'b1);
        gap_ceiling = 0;
        send_block(BLOCK_MAX + 4, 17);
        release_start();
    endtask

    task automatic test_pause_drain();
        // The sender holds off until the whole block has been emitted.
        gap_ceiling = 7;
        send_block($urandom_range(2, 9), $urandom_range(0, 17));
        wait_for_codes();
        gap_ceiling = 0;
        send_block($urandom_range(2, 9), $urandom_range(0, 17));
        release_start();
    endtask

    task automatic test_random_blocks();
        int pick;
        int len;
        while (values_sent < VALUE_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = $urandom_range(1, 12);
            end else if (pick < 18) begin
                len = $urandom_range(13, BLOCK_MAX - 1);
            end else if (pick == 18) begin
                len = BLOCK_MAX;
            end else begin
                len = $urandom_range(BLOCK_MAX + 1, BLOCK_MAX + 7);
            end
            gap_ceiling = ($urandom_range(0, 3) == 0) ? 0 : 7;
            send_block(len, $urandom_range(0, 17));
            if ($urandom_range(0, 7) == 0) begin
                wait_for_codes();
            end
        end
        release_start();
    endtask

    initial begin
        errors = 0;
        values_sent = 0;
        values_dropped = 0;
        blocks_closed = 0;
        headers_checked = 0;
        codes_checked = 0;
        gap_ceiling = 0;
        held_count = 0;
        splits_chosen = '0;
        for (int k = 0; k < SPLIT_OPTIONS; k++) begin
            run_costs[k] = '0;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_single_value_blocks();
        test_short_blocks();
        test_buffer_full();
        test_pause_drain();
        test_random_blocks();
        wait_for_codes();

        if (pending_codes.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_codes.size()));
        end
        $display("Encoded %0d values in %0d blocks, %0d of them dropped by a full buffer.",
                 values_sent, blocks_closed, values_dropped);
        $display("Checked %0d headers and %0d codes; %0d distinct split counts chosen.",
                 headers_checked, codes_checked, $countones(splits_chosen));
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
